/* design/hrhp_pkg.sv */
package hrhp_pkg;

   // Result codes carried on the result channel.
   localparam logic [2:0] CODE_OK             = 3'd0;
   localparam logic [2:0] CODE_INCOMPLETE     = 3'd1;
   localparam logic [2:0] CODE_MALFORMED      = 3'd2;
   localparam logic [2:0] CODE_BAD_LENGTH     = 3'd3;
   localparam logic [2:0] CODE_CHUNKED_LENGTH = 3'd4;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

   localparam int unsigned PREFIX_LEN   = 7;
   localparam int unsigned CL_NAME_LEN  = 14;
   localparam int unsigned TE_NAME_LEN  = 17;
   localparam int unsigned CHUNKED_LEN  = 7;
   localparam int unsigned VALUE_LIMIT  = 32;
   localparam int unsigned STATUS_MIN   = 100;
   localparam int unsigned STATUS_MAX   = 599;

   typedef enum logic [1:0] {
      PH_STATUS,
      PH_NAME,
      PH_LEAD,
      PH_VALUE
   } phase_type;

   typedef enum logic [1:0] {
      TERM_NONE,
      TERM_CR,
      TERM_CRLF,
      TERM_CRLFCR
   } term_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [9:0]  status_code;
      logic [15:0] header_length;
      logic [31:0] body_length;
      logic        chunked_flag;
   } result_type;

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic [7:0] prefix_char(logic [2:0] i);
      case (i)
         3'd0:    return "H";
         3'd1:    return "T";
         3'd2:    return "T";
         3'd3:    return "P";
         3'd4:    return "/";
         3'd5:    return "1";
         3'd6:    return ".";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] cl_char(logic [4:0] i);
      case (i)
         5'd0:    return "c";
         5'd1:    return "o";
         5'd2:    return "n";
         5'd3:    return "t";
         5'd4:    return "e";
         5'd5:    return "n";
         5'd6:    return "t";
         5'd7:    return "-";
         5'd8:    return "l";
         5'd9:    return "e";
         5'd10:   return "n";
         5'd11:   return "g";
         5'd12:   return "t";
         5'd13:   return "h";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] te_char(logic [4:0] i);
      case (i)
         5'd0:    return "t";
         5'd1:    return "r";
         5'd2:    return "a";
         5'd3:    return "n";
         5'd4:    return "s";
         5'd5:    return "f";
         5'd6:    return "e";
         5'd7:    return "r";
         5'd8:    return "-";
         5'd9:    return "e";
         5'd10:   return "n";
         5'd11:   return "c";
         5'd12:   return "o";
         5'd13:   return "d";
         5'd14:   return "i";
         5'd15:   return "n";
         5'd16:   return "g";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] chunked_char(logic [2:0] i);
      case (i)
         3'd0:    return "c";
         3'd1:    return "h";
         3'd2:    return "u";
         3'd3:    return "n";
         3'd4:    return "k";
         3'd5:    return "e";
         3'd6:    return "d";
         default: return 8'h00;
      endcase
   endfunction

endpackage

/* design/hrhp_core.sv */
module hrhp_core #(
   parameter int unsigned POSITION_BITS = 16,
   parameter int unsigned LENGTH_BITS   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output logic                 emit,
   output hrhp_pkg::result_type result
);

   typedef struct packed {
      hrhp_pkg::phase_type    phase;
      logic [2:0]             st_prog;
      logic [9:0]             st_val;
      logic                   st_bad;
      logic [2:0]             line_err;
      logic [4:0]             name_idx;
      logic [1:0]             alive;
      logic [5:0]             val_len;
      logic [LENGTH_BITS-1:0] acc;
      logic                   val_digit;
      logic                   val_bad;
      logic [LENGTH_BITS-1:0] len_reg;
      logic                   chunked;
   } parse_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   function automatic parse_type clear_line(parse_type s);
      parse_type r;
      r = s;
      r.phase     = hrhp_pkg::PH_NAME;
      r.name_idx  = '0;
      r.alive     = 2'b11;
      r.val_len   = '0;
      r.acc       = '0;
      r.val_digit = 1'b0;
      r.val_bad   = 1'b0;
      return r;
   endfunction

   function automatic parse_type parse_reset();
      parse_type r;
      r = '0;
      r = clear_line(r);
      r.phase    = hrhp_pkg::PH_STATUS;
      r.line_err = hrhp_pkg::CODE_OK;
      return r;
   endfunction

   function automatic parse_type value_byte(parse_type s, logic [7:0] c);
      parse_type              r;
      logic [LENGTH_BITS+3:0] wide;
      r = s;
      wide = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + (LENGTH_BITS + 4)'(c[3:0]);
      if (s.alive[0]) begin
         if (s.val_len == '0 && c == hrhp_pkg::CHAR_PLUS) begin
            r.val_bad = s.val_bad;
         end else if (hrhp_pkg::is_digit(c)) begin
            // Anything that spills into the top nibble is past the maximum.
            r.acc = (wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1 : wide[LENGTH_BITS-1:0];
            r.val_digit = 1'b1;
         end else begin
            r.val_bad = 1'b1;
         end
      end else if (s.alive[1]) begin
         if (s.val_len >= 6'(hrhp_pkg::CHUNKED_LEN) ||
             hrhp_pkg::to_lower(c) != hrhp_pkg::chunked_char(s.val_len[2:0])) begin
            r.val_bad = 1'b1;
         end
      end
      if (s.val_len != 6'd63) begin
         r.val_len = s.val_len + 6'd1;
      end
      return r;
   endfunction

   function automatic parse_type content_step(parse_type s, logic [7:0] c);
      parse_type  r;
      logic [7:0] lc;
      logic [1:0] keep;
      r = s;
      lc = hrhp_pkg::to_lower(c);
      keep = 2'b00;
      if (s.phase == hrhp_pkg::PH_STATUS) begin
         if (s.st_prog == 3'd0) begin
            if (c == hrhp_pkg::CHAR_SPACE) begin
               r.st_prog = 3'd1;
            end
         end else if (s.st_prog < 3'd4) begin
            if (hrhp_pkg::is_digit(c)) begin
               r.st_val  = 10'(({3'd0, s.st_val} << 3) + ({3'd0, s.st_val} << 1) +
                               13'(c[3:0]));
               r.st_prog = s.st_prog + 3'd1;
            end else begin
               r.st_bad  = 1'b1;
               r.st_prog = 3'd4;
            end
         end
      end else if (s.line_err != hrhp_pkg::CODE_OK) begin
         r = s;
      end else if (s.phase == hrhp_pkg::PH_NAME) begin
         if (c == hrhp_pkg::CHAR_COLON) begin
            keep[0] = s.alive[0] && s.name_idx == 5'(hrhp_pkg::CL_NAME_LEN);
            keep[1] = s.alive[1] && s.name_idx == 5'(hrhp_pkg::TE_NAME_LEN);
            r.alive = keep;
            r.phase = hrhp_pkg::PH_LEAD;
         end else begin
            if (s.alive[0] && (s.name_idx >= 5'(hrhp_pkg::CL_NAME_LEN) ||
                               lc != hrhp_pkg::cl_char(s.name_idx))) begin
               r.alive[0] = 1'b0;
            end
            if (s.alive[1] && (s.name_idx >= 5'(hrhp_pkg::TE_NAME_LEN) ||
                               lc != hrhp_pkg::te_char(s.name_idx))) begin
               r.alive[1] = 1'b0;
            end
            if (s.name_idx != 5'd31) begin
               r.name_idx = s.name_idx + 5'd1;
            end
         end
      end else if (s.phase == hrhp_pkg::PH_LEAD &&
                   (c == hrhp_pkg::CHAR_SPACE || c == hrhp_pkg::CHAR_TAB)) begin
         r = s;
      end else begin
         r.phase = hrhp_pkg::PH_VALUE;
         r = value_byte(r, c);
      end
      return r;
   endfunction

   function automatic parse_type end_line(parse_type s);
      parse_type r;
      r = s;
      if (s.phase == hrhp_pkg::PH_STATUS) begin
         if (s.st_prog != 3'd4) begin
            r.st_bad = 1'b1;
         end
      end else if (s.line_err == hrhp_pkg::CODE_OK) begin
         if (s.phase == hrhp_pkg::PH_NAME) begin
            r.line_err = hrhp_pkg::CODE_MALFORMED;
         end else if (s.alive[0]) begin
            if (s.val_len == '0 || s.val_len >= 6'(hrhp_pkg::VALUE_LIMIT) ||
                !s.val_digit || s.val_bad) begin
               r.line_err = hrhp_pkg::CODE_BAD_LENGTH;
            end else begin
               r.len_reg = s.acc;
            end
         end else if (s.alive[1]) begin
            if (s.val_len == 6'(hrhp_pkg::CHUNKED_LEN) && !s.val_bad) begin
               r.chunked = 1'b1;
            end
         end
      end
      return clear_line(r);
   endfunction

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   hrhp_pkg::term_type       term_ff, term_in;
   logic                     finished_ff, finished_in;
   parse_type                parse_ff, parse_in;

   parse_type                pre_state;
   parse_type                cr_state;
   parse_type                new_state;
   logic [POSITION_BITS-1:0] new_pos;
   logic                     prev_cr;
   logic                     header_end;

   // Next state: position and prefix checks first, then the line logic.
   always_comb begin
      pre_state  = parse_ff;
      new_pos    = pos_ff;
      prev_cr    = (term_ff == hrhp_pkg::TERM_CR) || (term_ff == hrhp_pkg::TERM_CRLFCR);
      header_end = 1'b0;
      term_in    = term_ff;
      if (pos_ff == POS_MAX) begin
         if (parse_ff.line_err == hrhp_pkg::CODE_OK) begin
            pre_state.line_err = hrhp_pkg::CODE_MALFORMED;
         end
      end else begin
         new_pos = pos_ff + POSITION_BITS'(1);
      end
      if (pos_ff < POSITION_BITS'(hrhp_pkg::PREFIX_LEN) &&
          data_byte != hrhp_pkg::prefix_char(pos_ff[2:0])) begin
         pre_state.st_bad = 1'b1;
      end
      // A CR that was held back is an ordinary byte unless LF follows it.
      cr_state  = prev_cr ? content_step(pre_state, hrhp_pkg::CHAR_CR) : pre_state;
      new_state = cr_state;
      if (data_byte == hrhp_pkg::CHAR_LF && prev_cr) begin
         if (term_ff == hrhp_pkg::TERM_CRLFCR) begin
            term_in    = hrhp_pkg::TERM_NONE;
            header_end = 1'b1;
            new_state  = pre_state;
         end else begin
            term_in   = hrhp_pkg::TERM_CRLF;
            new_state = end_line(pre_state);
         end
      end else if (data_byte == hrhp_pkg::CHAR_CR) begin
         term_in = (term_ff == hrhp_pkg::TERM_CRLF) ? hrhp_pkg::TERM_CRLFCR
                                                    : hrhp_pkg::TERM_CR;
      end else begin
         term_in   = hrhp_pkg::TERM_NONE;
         new_state = content_step(cr_state, data_byte);
      end

      pos_in      = new_pos;
      parse_in    = new_state;
      finished_in = header_end;
      if (finished_ff) begin
         pos_in      = pos_ff;
         parse_in    = parse_ff;
         term_in     = term_ff;
         finished_in = 1'b1;
      end
      if (last_byte) begin
         pos_in      = '0;
         parse_in    = parse_reset();
         term_in     = hrhp_pkg::TERM_NONE;
         finished_in = 1'b0;
      end
   end

   // Result for the current beat, taken from the updated state.
   always_comb begin
      result = '0;
      emit   = 1'b0;
      if (!finished_ff && header_end) begin
         emit                  = 1'b1;
         result.status_code    = new_state.st_val;
         result.header_length  = 16'(new_pos);
         result.body_length    = 32'(new_state.len_reg);
         result.chunked_flag   = new_state.chunked;
         if (new_state.st_bad || new_state.st_val < 10'(hrhp_pkg::STATUS_MIN) ||
             new_state.st_val > 10'(hrhp_pkg::STATUS_MAX)) begin
            result.result_code    = hrhp_pkg::CODE_MALFORMED;
            result.status_code    = new_state.st_bad ? 10'd0 : new_state.st_val;
            result.body_length    = '0;
            result.chunked_flag   = 1'b0;
         end else if (new_state.line_err != hrhp_pkg::CODE_OK) begin
            result.result_code = new_state.line_err;
         end else if (new_state.chunked && new_state.len_reg != '0) begin
            result.result_code = hrhp_pkg::CODE_CHUNKED_LENGTH;
         end else begin
            result.result_code = hrhp_pkg::CODE_OK;
         end
      end else if (!finished_ff && last_byte) begin
         emit               = 1'b1;
         result.result_code = hrhp_pkg::CODE_INCOMPLETE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         term_ff     <= hrhp_pkg::TERM_NONE;
         finished_ff <= 1'b0;
         parse_ff    <= parse_reset();
      end else if (step) begin
         pos_ff      <= pos_in;
         term_ff     <= term_in;
         finished_ff <= finished_in;
         parse_ff    <= parse_in;
      end
   end

endmodule

/* design/http_response_header_parser_top.sv */
// HTTP/1.x response header parser.
// The req channel carries one byte of the response buffer per beat, with
// req_last_byte marking the final byte of a buffer. The rsp channel carries
// at most one result per buffer: a result code with the status, header
// length, Content-Length and chunked flag once CR LF CR LF is seen, or an
// incomplete result on the last byte if the header never ended. Bytes after
// the header end are absorbed without effect until the last byte, after
// which the parser starts afresh for the next buffer.
// A byte is held in an input register and parsed when it advances, and its
// result, if any, is loaded into the output register that drives rsp. One
// byte is taken per cycle as long as the output register is free or being
// drained. When the receiver stalls with a result pending, parsing pauses;
// the input register still takes one byte, and req_ready then drops until
// the result beat is taken. Reset clears the parser state and empties both
// registers.
module http_response_header_parser_top #(
   parameter int unsigned POSITION_BITS = 16,
   parameter int unsigned LENGTH_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_code,
   output logic [9:0]  rsp_status_code,
   output logic [15:0] rsp_header_length,
   output logic [31:0] rsp_body_length,
   output logic        rsp_chunked_flag
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   hrhp_pkg::result_type rsp_ff;
   hrhp_pkg::result_type core_result;
   logic                 core_emit;
   logic                 advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   hrhp_core #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .emit      (core_emit),
      .result    (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && core_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && core_emit) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_code    = rsp_ff.result_code;
   assign rsp_status_code    = rsp_ff.status_code;
   assign rsp_header_length  = rsp_ff.header_length;
   assign rsp_body_length    = rsp_ff.body_length;
   assign rsp_chunked_flag   = rsp_ff.chunked_flag;

   // An incomplete result carries no other information.
   a_incomplete_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_code == hrhp_pkg::CODE_INCOMPLETE |->
         rsp_ff.status_code == 10'd0 && rsp_ff.header_length == 16'd0 &&
         rsp_ff.body_length == 32'd0 && !rsp_ff.chunked_flag)
      else $error("incomplete result with nonzero fields");

   // A good result always has a status in the legal range.
   a_ok_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_code == hrhp_pkg::CODE_OK |->
         rsp_ff.status_code >= 10'd100 && rsp_ff.status_code <= 10'd599)
      else $error("ok result with status out of range");

   a_chunked_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_code == hrhp_pkg::CODE_CHUNKED_LENGTH |->
         rsp_ff.chunked_flag && rsp_ff.body_length != 32'd0)
      else $error("chunked code without chunked flag and length");

   // While a result waits, the byte in the input register must not be parsed.
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost during output stall");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.result_code <= hrhp_pkg::CODE_CHUNKED_LENGTH)
      else $error("result code out of range");

endmodule
